/* hdl/pbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and codes of the power bisector polygon clipper.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SITE_X       = 3'd0,
    REG_SITE_Y       = 3'd1,
    REG_SITE_WEIGHT  = 3'd2,
    REG_OTHER_X      = 3'd3,
    REG_OTHER_Y      = 3'd4,
    REG_OTHER_WEIGHT = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    TERM_PX = 3'd0,
    TERM_PY = 3'd1,
    TERM_SX = 3'd2,
    TERM_SY = 3'd3,
    TERM_OX = 3'd4,
    TERM_OY = 3'd5
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB,
    ST_DECIDE,
    ST_FA,
    ST_CHECK_A,
    ST_LINIT,
    ST_MUL,
    ST_DIV,
    ST_RND,
    ST_EMIT_C,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic  load_in;
    logic  f_step;
    term_t term;
    logic  pt_a;
    logic  lerp_init;
    logic  coord;
    logic  mul_step;
    logic  div_step;
    logic  lerp_fin;
    logic  clamp_prev;
    logic  out_load;
    logic  out_sel_b;
    logic  out_last;
    logic  commit;
  } dp_cmd_t;

  typedef struct packed {
    logic b_in;
    logic a_in;
    logic prev_inside;
    logic prime;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/pbc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_if
// Valid/ready channels for vertices, output vertices and register writes.
// ----------------------------------------------------------------------------
interface pbc_vtx_if #(parameter int FRAC = 16);
  logic            valid;
  logic            ready;
  logic [FRAC:0]   vertex_x;
  logic [FRAC:0]   vertex_y;
  logic            prime;
  modport source (output valid, vertex_x, vertex_y, prime, input ready);
  modport sink   (input valid, vertex_x, vertex_y, prime, output ready);
endinterface

interface pbc_res_if #(parameter int FRAC = 16);
  logic            valid;
  logic            ready;
  logic [FRAC:0]   out_x;
  logic [FRAC:0]   out_y;
  logic            last_of_run;
  modport source (output valid, out_x, out_y, last_of_run, input ready);
  modport sink   (input valid, out_x, out_y, last_of_run, output ready);
endinterface

interface pbc_cfg_if #(parameter int FRAC = 16);
  logic                          valid;
  logic                          ready;
  logic [pbc_pkg::CFG_IDX_W-1:0] reg_index;
  logic [FRAC+2:0]               data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

/* hdl/power_bisector_polygon_clip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_bisector_polygon_clip
// One Sutherland-Hodgman pass of a 2D polygon against a power bisector.
// ----------------------------------------------------------------------------
// Registers are written through cfg (index, data), always ready. The user
// must write them only while the block is idle; the block itself does not
// enforce it. Vertices enter on in_ch: first the closing vertex with prime
// set, then every vertex in order. Each vertex produces zero, one or two
// output vertices on out_ch; last_of_run marks the final one.
// A vertex is taken only in the idle state. The power test of one point is
// a multiply-accumulate over the terms PX, PY, SX, SY, OX and OY on a
// single multiplier. A vertex on the other side of the previous one adds a
// power test of the previous vertex. If that test no longer agrees with the
// stored flag, the crossing is at the previous vertex itself and it is
// output clamped; else a true crossing adds two interpolations (shift-add
// multiply, restoring divide, rounding).
// Results sit in an output register; a stalled receiver holds the block
// only when a further result must be loaded. Reset clears the registers,
// the previous vertex and its flag, and empties the output.
// ----------------------------------------------------------------------------
module power_bisector_polygon_clip #(
  parameter int COORD_FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  pbc_vtx_if.sink   in_ch,
  pbc_res_if.source out_ch,
  pbc_cfg_if.sink   cfg
);
  pbc_pkg::dp_cmd_t    cmd;
  pbc_pkg::dp_status_t status;

  assign cfg.ready = 1'b1;

  pbc_ctrl #(.FRAC(COORD_FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  pbc_datapath #(.FRAC(COORD_FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_x      (in_ch.vertex_x),
    .in_y      (in_ch.vertex_y),
    .in_prime  (in_ch.prime),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_last  (out_ch.last_of_run)
  );

endmodule

/* hdl/pbc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_datapath
// Registers, power test multiply-accumulate, shift-add multiplier, restoring
// divider and output register of the clipper.
// ----------------------------------------------------------------------------
module pbc_datapath #(
  parameter int FRAC = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pbc_pkg::dp_cmd_t              cmd,
  output pbc_pkg::dp_status_t           status,
  input  logic [FRAC:0]                 in_x,
  input  logic [FRAC:0]                 in_y,
  input  logic                          in_prime,
  input  logic                          cfg_we,
  input  logic [pbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC+2:0]               cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRAC:0]                 out_x,
  output logic [FRAC:0]                 out_y,
  output logic                          out_last
);
  localparam int CW = FRAC + 1;
  localparam int WW = FRAC + 3;
  localparam int PW = 2 * CW + 2;
  localparam int FW = 2 * CW + 4;
  localparam int RW = FW + CW;
  localparam int QW = CW + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC;

  logic [CW-1:0]        site_x, site_y, other_x, other_y;
  logic signed [WW-1:0] site_weight, other_weight;
  logic [CW-1:0]        prev_x, prev_y, bx, by, cx, cy, la;
  logic                 prev_inside, prime;
  logic signed [FW-1:0] acc, acc_next, fa, fb, wt, pext;
  logic signed [CW:0]   dx, dy, ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [WW:0]   wdiff;
  logic [CW-1:0]        px, py;
  logic [FW-1:0]        naa, nab, den;
  logic [RW-1:0]        rem, nash, dsh;
  logic [CW-1:0]        dreg;
  logic                 up;
  logic [QW-1:0]        q, qr, sum;
  logic [CW-1:0]        lres, a_sel, b_sel;

  function automatic logic is_in(input logic signed [FW-1:0] f);
    return f[FW-1] || (f == '0);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      site_x       <= '0;
      site_y       <= '0;
      other_x      <= '0;
      other_y      <= '0;
      site_weight  <= '0;
      other_weight <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbc_pkg::REG_SITE_X:       site_x       <= cfg_data[CW-1:0];
        pbc_pkg::REG_SITE_Y:       site_y       <= cfg_data[CW-1:0];
        pbc_pkg::REG_SITE_WEIGHT:  site_weight  <= $signed(cfg_data);
        pbc_pkg::REG_OTHER_X:      other_x      <= cfg_data[CW-1:0];
        pbc_pkg::REG_OTHER_Y:      other_y      <= cfg_data[CW-1:0];
        pbc_pkg::REG_OTHER_WEIGHT: other_weight <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign dx    = $signed({1'b0, other_x}) - $signed({1'b0, site_x});
  assign dy    = $signed({1'b0, other_y}) - $signed({1'b0, site_y});
  assign wdiff = {site_weight[WW-1], site_weight} - {other_weight[WW-1], other_weight};
  assign wt    = $signed({{(FW - WW - 1){wdiff[WW]}}, wdiff}) <<< FRAC;
  assign px    = cmd.pt_a ? prev_x : bx;
  assign py    = cmd.pt_a ? prev_y : by;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.term)
      pbc_pkg::TERM_PX: begin ma = $signed({1'b0, px}); mb = dx; end
      pbc_pkg::TERM_PY: begin ma = $signed({1'b0, py}); mb = dy; end
      pbc_pkg::TERM_SX: begin ma = $signed({1'b0, site_x}); mb = ma; end
      pbc_pkg::TERM_SY: begin ma = $signed({1'b0, site_y}); mb = ma; end
      pbc_pkg::TERM_OX: begin ma = $signed({1'b0, other_x}); mb = ma; end
      pbc_pkg::TERM_OY: begin ma = $signed({1'b0, other_y}); mb = ma; end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign pext = $signed({{(FW - PW){prod[PW-1]}}, prod});

  always_comb begin
    case (cmd.term)
      pbc_pkg::TERM_PX: acc_next = (pext <<< 1) - wt;
      pbc_pkg::TERM_PY: acc_next = acc + (pext <<< 1);
      pbc_pkg::TERM_SX,
      pbc_pkg::TERM_SY: acc_next = acc + pext;
      pbc_pkg::TERM_OX,
      pbc_pkg::TERM_OY: acc_next = acc - pext;
      default:          acc_next = acc;
    endcase
  end

  assign naa   = fa[FW-1] ? FW'(-fa) : FW'(fa);
  assign nab   = fb[FW-1] ? FW'(-fb) : FW'(fb);
  assign a_sel = cmd.coord ? prev_y : prev_x;
  assign b_sel = cmd.coord ? by : bx;
  assign qr    = q + QW'(({rem, 1'b0} >= {{(RW - FW + 1){1'b0}}, den}) ? 1 : 0);
  assign sum   = up ? ({1'b0, la} + qr) : ({1'b0, la} - qr);
  assign lres  = (sum > {1'b0, ONE}) ? ONE : sum[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bx    <= in_x;
      by    <= in_y;
      prime <= in_prime;
    end
    if (cmd.f_step) begin
      acc <= acc_next;
      if (cmd.term == pbc_pkg::TERM_OY) begin
        if (cmd.pt_a) fa <= acc_next;
        else          fb <= acc_next;
      end
    end
    if (cmd.lerp_init) begin
      up   <= b_sel >= a_sel;
      dreg <= (b_sel >= a_sel) ? b_sel - a_sel : a_sel - b_sel;
      la   <= a_sel;
      den  <= naa + nab;
      rem  <= '0;
      nash <= RW'(naa);
      dsh  <= RW'(naa + nab) << CW;
      q    <= '0;
    end
    if (cmd.mul_step) begin
      if (dreg[0]) rem <= rem + nash;
      nash <= nash << 1;
      dreg <= dreg >> 1;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) rem <= rem - dsh;
      q   <= {q[QW-2:0], rem >= dsh};
      dsh <= dsh >> 1;
    end
    if (cmd.lerp_fin) begin
      if (cmd.coord) cy <= lres;
      else           cx <= lres;
    end
    if (cmd.clamp_prev) begin
      cx <= (prev_x > ONE) ? ONE : prev_x;
      cy <= (prev_y > ONE) ? ONE : prev_y;
    end
    if (cmd.out_load) begin
      out_x    <= cmd.out_sel_b ? bx : cx;
      out_y    <= cmd.out_sel_b ? by : cy;
      out_last <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_inside <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        prev_x      <= bx;
        prev_y      <= by;
        prev_inside <= is_in(fb);
      end
      if (cmd.out_load)     out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  assign status.b_in        = is_in(fb);
  assign status.a_in        = is_in(fa);
  assign status.prev_inside = prev_inside;
  assign status.prime       = prime;
  assign status.out_free    = !out_valid || out_ready;

endmodule

/* hdl/pbc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer of the clipper: power tests, interpolation and output order.
// ----------------------------------------------------------------------------
module pbc_ctrl #(
  parameter int FRAC = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output pbc_pkg::dp_cmd_t    cmd,
  input  pbc_pkg::dp_status_t status
);
  localparam int CW    = FRAC + 1;
  localparam int CNT_W = $clog2(CW + 2);

  pbc_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             coord, coord_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbc_pkg::ST_IDLE;
      cnt   <= '0;
      coord <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      coord <= coord_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    coord_next = coord;
    case (state)
      pbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pbc_pkg::ST_FB;
          cnt_next   = '0;
        end
      end
      pbc_pkg::ST_FB, pbc_pkg::ST_FA: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(pbc_pkg::TERM_OY)) begin
          state_next = (state == pbc_pkg::ST_FB) ? pbc_pkg::ST_DECIDE : pbc_pkg::ST_CHECK_A;
        end
      end
      pbc_pkg::ST_DECIDE: begin
        cnt_next = '0;
        if (status.prime)                            state_next = pbc_pkg::ST_IDLE;
        else if (status.b_in != status.prev_inside)  state_next = pbc_pkg::ST_FA;
        else if (status.b_in)                        state_next = pbc_pkg::ST_EMIT_B;
        else                                         state_next = pbc_pkg::ST_IDLE;
      end
      pbc_pkg::ST_CHECK_A: begin
        coord_next = 1'b0;
        state_next = (status.a_in == status.prev_inside) ? pbc_pkg::ST_LINIT
                                                         : pbc_pkg::ST_EMIT_C;
      end
      pbc_pkg::ST_LINIT: begin
        cnt_next   = '0;
        state_next = pbc_pkg::ST_MUL;
      end
      pbc_pkg::ST_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CW - 1)) begin
          cnt_next   = '0;
          state_next = pbc_pkg::ST_DIV;
        end
      end
      pbc_pkg::ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CW)) state_next = pbc_pkg::ST_RND;
      end
      pbc_pkg::ST_RND: begin
        coord_next = 1'b1;
        state_next = coord ? pbc_pkg::ST_EMIT_C : pbc_pkg::ST_LINIT;
      end
      pbc_pkg::ST_EMIT_C: begin
        if (status.out_free) begin
          state_next = status.b_in ? pbc_pkg::ST_EMIT_B : pbc_pkg::ST_IDLE;
        end
      end
      pbc_pkg::ST_EMIT_B: begin
        if (status.out_free) state_next = pbc_pkg::ST_IDLE;
      end
      default: state_next = pbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cmd.term = pbc_pkg::term_t'(cnt[2:0]);
    cmd.coord = coord;
    case (state)
      pbc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      pbc_pkg::ST_FB: cmd.f_step = 1'b1;
      pbc_pkg::ST_FA: begin
        cmd.f_step = 1'b1;
        cmd.pt_a   = 1'b1;
      end
      pbc_pkg::ST_DECIDE: begin
        cmd.commit = status.prime ||
                     (status.b_in == status.prev_inside && !status.b_in);
      end
      pbc_pkg::ST_CHECK_A: cmd.clamp_prev = (status.a_in != status.prev_inside);
      pbc_pkg::ST_LINIT:   cmd.lerp_init = 1'b1;
      pbc_pkg::ST_MUL:     cmd.mul_step = 1'b1;
      pbc_pkg::ST_DIV:     cmd.div_step = 1'b1;
      pbc_pkg::ST_RND:     cmd.lerp_fin = 1'b1;
      pbc_pkg::ST_EMIT_C: begin
        cmd.out_load = status.out_free;
        cmd.out_last = !status.b_in;
        cmd.commit   = status.out_free && !status.b_in;
      end
      pbc_pkg::ST_EMIT_B: begin
        cmd.out_load  = status.out_free;
        cmd.out_sel_b = 1'b1;
        cmd.out_last  = 1'b1;
        cmd.commit    = status.out_free;
      end
      default: ;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free) else $error("output loaded while occupied");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == pbc_pkg::ST_IDLE) else $error("commit not at end of item");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_in && cmd.commit)) else $error("load and commit together");
  a_prime_silent: assert property (@(posedge clk) disable iff (rst)
    (state == pbc_pkg::ST_DECIDE && status.prime) |=> state == pbc_pkg::ST_IDLE)
    else $error("primed vertex produced work");

endmodule

/* tb/power_bisector_polygon_clip_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_bisector_polygon_clip_tb
// Self-checking bench for the power bisector polygon clipper. Polygons are
// streamed as a primed closing vertex followed by every vertex, under
// several site and weight settings, with bursty input and a stalling
// receiver. A scoreboard predicts every output vertex bit for bit.
// ----------------------------------------------------------------------------
module power_bisector_polygon_clip_tb;

  localparam int FRAC = 16;
  localparam int CWID = FRAC + 1;
  localparam int WWID = FRAC + 3;
  localparam logic [CWID-1:0] ONE = CWID'(1) << FRAC;

  typedef struct packed {
    logic [CWID-1:0] x;
    logic [CWID-1:0] y;
    logic            last;
  } clip_vertex_t;

  class clip_scoreboard;
    logic [CWID-1:0] sx, sy, ox, oy;
    logic signed [WWID-1:0] sw, ow;
    logic [CWID-1:0] px, py;
    logic p_in;
    clip_vertex_t pending[$];
    int errors;
    int checked;

    function void clear();
      sx = 0; sy = 0; ox = 0; oy = 0; sw = 0; ow = 0;
      px = 0; py = 0; p_in = 0;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(pbc_pkg::reg_index_t idx, logic [WWID-1:0] d);
      case (idx)
        pbc_pkg::REG_SITE_X:       sx = d[CWID-1:0];
        pbc_pkg::REG_SITE_Y:       sy = d[CWID-1:0];
        pbc_pkg::REG_SITE_WEIGHT:  sw = d;
        pbc_pkg::REG_OTHER_X:      ox = d[CWID-1:0];
        pbc_pkg::REG_OTHER_Y:      oy = d[CWID-1:0];
        pbc_pkg::REG_OTHER_WEIGHT: ow = d;
        default: ;
      endcase
    endfunction

    function logic signed [95:0] power_of(logic [CWID-1:0] x, logic [CWID-1:0] y);
      logic signed [95:0] f;
      f = 2 * ($signed({1'b0, x}) * ($signed({1'b0, ox}) - $signed({1'b0, sx}))
        + $signed({1'b0, y}) * ($signed({1'b0, oy}) - $signed({1'b0, sy})));
      f = f + $signed({1'b0, sx}) * $signed({1'b0, sx})
            + $signed({1'b0, sy}) * $signed({1'b0, sy});
      f = f - $signed({1'b0, ox}) * $signed({1'b0, ox})
            - $signed({1'b0, oy}) * $signed({1'b0, oy});
      f = f - (($signed(96'(sw)) - $signed(96'(ow))) <<< FRAC);
      return f;
    endfunction

    function logic [CWID-1:0] interp(logic [CWID-1:0] a, logic [CWID-1:0] b,
                                     logic [95:0] na, logic [95:0] den);
      logic [127:0] prod, q, r;
      logic [CWID+1:0] res;
      logic up;
      up = b >= a;
      prod = na * (up ? b - a : a - b);
      q = prod / den;
      r = prod % den;
      if (r >= den - r) q = q + 128'd1;
      res = (CWID+2)'(up ? a + q : a - q);
      return (res > ONE) ? ONE : res[CWID-1:0];
    endfunction

    function void note_vertex(logic [CWID-1:0] bx, logic [CWID-1:0] by, logic prime);
      logic signed [95:0] fa, fb;
      logic b_in;
      clip_vertex_t c;
      fb = power_of(bx, by);
      b_in = fb <= 0;
      if (!prime) begin
        if (b_in != p_in) begin
          fa = power_of(px, py);
          if ((fa <= 0) == p_in) begin
            c.x = interp(px, bx, fa < 0 ? -fa : fa, (fa < 0 ? -fa : fa) + (fb < 0 ? -fb : fb));
            c.y = interp(py, by, fa < 0 ? -fa : fa, (fa < 0 ? -fa : fa) + (fb < 0 ? -fb : fb));
          end else begin
            c.x = px > ONE ? ONE : px;
            c.y = py > ONE ? ONE : py;
          end
          c.last = !b_in;
          pending = {pending, c};
        end
        if (b_in) begin
          c.x = bx; c.y = by; c.last = 1;
          pending = {pending, c};
        end
      end
      px = bx; py = by; p_in = b_in;
    endfunction

    task check_result(clip_vertex_t got);
      clip_vertex_t exp_v;
      checked++;
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected output vertex %h", got));
        return;
      end
      exp_v = pending.pop_front();
      if (got.x !== exp_v.x) report_error($sformatf("out_x %h, want %h", got.x, exp_v.x));
      if (got.y !== exp_v.y) report_error($sformatf("out_y %h, want %h", got.y, exp_v.y));
      if (got.last !== exp_v.last)
        report_error($sformatf("last_of_run %b, want %b", got.last, exp_v.last));
    endtask

    task report_error(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  pbc_vtx_if #(FRAC) in_ch();
  pbc_res_if #(FRAC) out_ch();
  pbc_cfg_if #(FRAC) cfg();

  power_bisector_polygon_clip #(.COORD_FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  clip_scoreboard sb = new();
  int sent = 0;
  int stall_mode;

  // Receiver stalls on its own pattern, with calm stretches.
  always @(negedge clk) begin
    if ((sent % 200) < 40) out_ch.ready <= 1;
    else case (stall_mode)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_x, out_ch.out_y, out_ch.last_of_run});
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_vertex(in_ch.vertex_x, in_ch.vertex_y, in_ch.prime);
      sent++;
    end
  end

  int burst_left;

  task automatic send_vertex(logic [CWID-1:0] x, logic [CWID-1:0] y, logic p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1; in_ch.vertex_x <= x; in_ch.vertex_y <= y; in_ch.prime <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(pbc_pkg::reg_index_t idx, logic [WWID-1:0] d);
    cfg.valid <= 1; cfg.reg_index <= idx; cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [CWID-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return ONE;
      2: return CWID'(ONE + $urandom_range(0, ONE - 1));
      default: return CWID'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic logic [WWID-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return WWID'(-(1 << (FRAC + 1)));
      1: return WWID'(1 << (FRAC + 1));
      2: return 0;
      default: return WWID'($urandom_range(0, (1 << WWID) - 1));
    endcase
  endfunction

  task automatic set_sites(logic [CWID-1:0] a, logic [CWID-1:0] b, logic [WWID-1:0] c,
                           logic [CWID-1:0] d, logic [CWID-1:0] e, logic [WWID-1:0] f);
    drain();
    write_reg(pbc_pkg::REG_SITE_X, a);
    write_reg(pbc_pkg::REG_SITE_Y, b);
    write_reg(pbc_pkg::REG_SITE_WEIGHT, c);
    write_reg(pbc_pkg::REG_OTHER_X, d);
    write_reg(pbc_pkg::REG_OTHER_Y, e);
    write_reg(pbc_pkg::REG_OTHER_WEIGHT, f);
    cfg.valid <= 0;
  endtask

  task automatic send_polygon(int n);
    logic [CWID-1:0] xs[16], ys[16];
    for (int i = 0; i < n; i++) begin
      xs[i] = rand_coord(); ys[i] = rand_coord();
    end
    send_vertex(xs[n-1], ys[n-1], 1'b1);
    for (int i = 0; i < n; i++) send_vertex(xs[i], ys[i], 1'b0);
  endtask

  initial begin
    in_ch.valid = 0; in_ch.vertex_x = 0; in_ch.vertex_y = 0; in_ch.prime = 0;
    cfg.valid = 0; cfg.reg_index = 0; cfg.data = 0;
    sb.clear();
    burst_left = 0; stall_mode = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // No prime after reset, all registers still zero.
    send_vertex(ONE, ONE, 0);
    send_vertex(0, 0, 0);
    // Identical sites, kept and dropped by weight.
    set_sites(ONE / 2, ONE / 2, WWID'(1 << (FRAC + 1)), ONE / 2, ONE / 2, 0);
    send_vertex(0, ONE, 1); send_vertex(ONE, 0, 0); send_vertex(ONE, ONE, 0);
    set_sites(ONE / 2, ONE / 2, WWID'(-(1 << (FRAC + 1))), ONE / 2, ONE / 2, 0);
    send_vertex(ONE, ONE, 0);
    // Unit square against the vertical bisector, then corners and above 1.0.
    set_sites(0, ONE / 2, 0, ONE, ONE / 2, 0);
    send_vertex(0, ONE, 1);
    send_vertex(0, 0, 0); send_vertex(ONE, 0, 0); send_vertex(ONE, ONE, 0);
    send_vertex(0, ONE, 0); send_vertex(17'h1FFFF, 17'h1FFFF, 0);
    send_vertex(0, 17'h1FFFF, 0); send_vertex(ONE / 3, 17'h15555, 0);
    // Register change in mid-polygon: previous vertex flips side.
    set_sites(ONE, ONE / 2, 0, 0, ONE / 2, 0);
    send_vertex(0, ONE / 4, 0); send_vertex(ONE, ONE / 4, 0);
    set_sites(0, 0, WWID'(1 << (FRAC + 1)), ONE, ONE, WWID'(-(1 << (FRAC + 1))));
    send_vertex(ONE, ONE, 0); send_vertex(0, 0, 0);
    while (sent < 720) begin
      stall_mode = $urandom_range(0, 2);
      set_sites(rand_coord() & 17'h1FFFF, rand_coord(), rand_weight(),
                rand_coord(), rand_coord(), rand_weight());
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        else
          send_polygon($urandom_range(3, 8));
      end
    end
    drain();
    $display("Covered %0d vertex transfers and %0d output vertices.", sent, sb.checked);
    $display("Site settings varied across random and extreme values, with stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout: stimulus or outputs stuck.");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

/* sim.f */
hdl/pbc_pkg.sv
hdl/pbc_if.sv
hdl/pbc_datapath.sv
hdl/pbc_ctrl.sv
hdl/power_bisector_polygon_clip.sv
tb/power_bisector_polygon_clip_tb.sv
